// ===== rtl/core/pgac_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgac_pkg
// Shared types and constants for the proximity gated audio conditioner.
// ----------------------------------------------------------------------------
package pgac_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int CMP_W           = 16;
  localparam int THR_W           = 10;
  localparam int TPC_W           = 8;
  localparam int CFG_W           = 10;
  localparam int CFG_IDX_W       = 1;
  localparam int NEAR_W          = 9;
  localparam int ACC_W           = 16;
  localparam int TIME_W          = 16;
  localparam int FRAME_W         = 16;
  localparam int CMD_W           = 8;
  localparam int BYTE_W          = 8;
  localparam int PROD_W          = TPC_W + NEAR_W;

  localparam logic [THR_W-1:0]  THR_RESET      = 10'd80;
  localparam logic [TPC_W-1:0]  TPC_RESET      = 8'd58;
  localparam logic [NEAR_W-1:0] NEAR_RESET     = 9'd2;
  localparam logic [ACC_W-1:0]  NEAR_LIMIT_MAX = 16'd400;

  // control characters
  localparam logic [CMD_W-1:0] CH_M  = 8'h4D;
  localparam logic [CMD_W-1:0] CH_D  = 8'h44;
  localparam logic [CMD_W-1:0] CH_0  = 8'h30;
  localparam logic [CMD_W-1:0] CH_9  = 8'h39;
  localparam logic [CMD_W-1:0] CH_LF = 8'h0A;
  localparam logic [CMD_W-1:0] CH_CR = 8'h0D;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS     = 1'b1;

  typedef enum logic [1:0] {
    FUNC_AUDIO   = 2'd0,
    FUNC_COMMAND = 2'd1,
    FUNC_ECHO    = 2'd2,
    FUNC_TICK    = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    KIND_AUDIO = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef struct packed {
    logic distance_mode;
    logic recording_on;
    logic recording_next;
  } ctrl_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/pgac_audio.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgac_audio
// Outlier rejection, pairwise averaging and decimation phase of audio samples.
// ----------------------------------------------------------------------------
module pgac_audio
  import pgac_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [THR_W-1:0]       threshold,
  output logic      [BYTE_W-1:0]      byte_out,
  output logic                        phase_next
);

  logic [SAMPLE_BITS-1:0] last_accepted;
  logic                   phase;
  logic [SAMPLE_BITS-1:0] diff;
  logic [SAMPLE_BITS-1:0] chosen;
  logic [SAMPLE_BITS:0]   sum;
  logic [SAMPLE_BITS-1:0] avg;
  logic                   reject;

  always_comb begin
    diff   = (sample >= last_accepted) ? (sample - last_accepted)
                                       : (last_accepted - sample);
    reject = CMP_W'(diff) > CMP_W'(threshold);
    chosen = reject ? last_accepted : sample;
    sum    = {1'b0, chosen} + {1'b0, last_accepted};
    avg    = sum[SAMPLE_BITS:1];
  end

  assign byte_out   = avg[SAMPLE_BITS-1 -: BYTE_W];
  assign phase_next = ~phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_accepted <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      phase         <= 1'b0;
    end else if (step) begin
      last_accepted <= chosen;
      phase         <= phase_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pgac_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pgac_ctrl
// Command parser, echo width capture and distance gate for recording.
// ----------------------------------------------------------------------------
module pgac_ctrl
  import pgac_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step_cmd,
  input  wire logic              step_echo,
  input  wire logic              step_tick,
  input  wire logic [CMD_W-1:0]  command_byte,
  input  wire logic [TIME_W-1:0] capture_time,
  input  wire logic [TPC_W-1:0]  ticks_per_cm,
  output ctrl_status_t           status
);

  logic              distance_mode;
  logic              recording_on;
  logic              entering_digits;
  logic [ACC_W-1:0]  digit_accumulator;
  logic [NEAR_W-1:0] near_limit_cm;
  logic              awaiting_fall;
  logic [TIME_W-1:0] rise_time;
  logic [TIME_W-1:0] echo_width;

  logic [PROD_W-1:0] upper;
  logic              in_window;
  logic              recording_next;
  logic [ACC_W-1:0]  acc_digit;
  logic              is_digit;
  logic              is_eol;
  logic              acc_in_range;

  always_comb begin
    upper          = PROD_W'(ticks_per_cm) * PROD_W'(near_limit_cm);
    in_window      = (PROD_W'(echo_width) > PROD_W'(ticks_per_cm))
                  && (PROD_W'(echo_width) < upper);
    recording_next = distance_mode ? in_window : recording_on;
    // acc * 10 + digit, wrapping at 16 bits
    acc_digit      = (digit_accumulator << 3) + (digit_accumulator << 1)
                   + ACC_W'(command_byte[3:0]);
    is_digit       = (command_byte >= CH_0) && (command_byte <= CH_9);
    is_eol         = (command_byte == CH_LF) || (command_byte == CH_CR);
    acc_in_range   = (digit_accumulator != '0) && (digit_accumulator < NEAR_LIMIT_MAX);
  end

  assign status.distance_mode  = distance_mode;
  assign status.recording_on   = recording_on;
  assign status.recording_next = recording_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_mode     <= 1'b0;
      recording_on      <= 1'b1;
      entering_digits   <= 1'b0;
      digit_accumulator <= '0;
      near_limit_cm     <= NEAR_RESET;
      awaiting_fall     <= 1'b0;
      rise_time         <= '0;
      echo_width        <= '0;
    end else begin
      if (step_cmd) begin
        if (command_byte == CH_M) begin
          distance_mode     <= 1'b0;
          recording_on      <= 1'b1;
          entering_digits   <= 1'b0;
          digit_accumulator <= '0;
        end else if (command_byte == CH_D) begin
          distance_mode     <= 1'b1;
          recording_on      <= 1'b0;
          entering_digits   <= 1'b1;
          digit_accumulator <= '0;
        end else if (entering_digits) begin
          if (is_digit) begin
            digit_accumulator <= acc_digit;
          end else if (is_eol) begin
            if (acc_in_range) begin
              near_limit_cm <= digit_accumulator[NEAR_W-1:0];
            end
            entering_digits   <= 1'b0;
            digit_accumulator <= '0;
          end
        end
      end
      if (step_echo && distance_mode) begin
        if (!awaiting_fall) begin
          rise_time     <= capture_time;
          awaiting_fall <= 1'b1;
        end else begin
          echo_width    <= capture_time - rise_time;
          awaiting_fall <= 1'b0;
        end
      end
      if (step_tick) begin
        recording_on <= recording_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/proximity_gated_audio_conditioner_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// proximity_gated_audio_conditioner_core
// Audio sample cleanup and decimation gated by an ultrasonic distance check.
// ----------------------------------------------------------------------------
// Takes one request per clock on the input channel: audio frames, command
// bytes, echo captures and ticks, selected by func. A request is held in an
// input register and fully processed once the output register can take a
// result; then the state is updated and any result is written to the output
// register. A new request is taken every cycle as long as the output side
// keeps up. The input and output registers hold one request and one result:
// while an untaken result sits in the output register, a request in the input
// register waits there, and in_ready drops once both are full. Audio frames
// give a byte on every second frame while recording (always in manual mode);
// ticks always give a status result; commands and echo captures give nothing.
// Configuration writes go straight into the registers and should be issued
// only while the block is idle.
// ----------------------------------------------------------------------------
module proximity_gated_audio_conditioner_core
  import pgac_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           func,
  input  wire logic [FRAME_W-1:0]   audio_frame,
  input  wire logic [CMD_W-1:0]     command_byte,
  input  wire logic [TIME_W-1:0]    capture_time,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      result_kind,
  output logic [BYTE_W-1:0]         audio_byte,
  output logic                      recording_flag,
  output logic                      trigger_pulse
);

  // configuration registers
  logic [THR_W-1:0] max_jump;
  logic [TPC_W-1:0] ticks_per_cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_jump     <= THR_RESET;
      ticks_per_cm <= TPC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: max_jump     <= cfg_data[THR_W-1:0];
        CFG_TICKS:     ticks_per_cm <= cfg_data[TPC_W-1:0];
        default:       ;
      endcase
    end
  end

  // input register
  logic               s1_valid;
  func_t              s1_func;
  logic [FRAME_W-1:0] s1_frame;
  logic [CMD_W-1:0]   s1_cmd;
  logic [TIME_W-1:0]  s1_time;
  logic               out_free;
  logic               s1_fire;

  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_free;
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func  <= func_t'(func);
      s1_frame <= audio_frame;
      s1_cmd   <= command_byte;
      s1_time  <= capture_time;
    end
  end

  // per-kind step strobes
  logic step_audio;
  logic step_cmd;
  logic step_echo;
  logic step_tick;

  always_comb begin
    step_audio = 1'b0;
    step_cmd   = 1'b0;
    step_echo  = 1'b0;
    step_tick  = 1'b0;
    unique case (s1_func)
      FUNC_AUDIO:   step_audio = s1_fire;
      FUNC_COMMAND: step_cmd   = s1_fire;
      FUNC_ECHO:    step_echo  = s1_fire;
      FUNC_TICK:    step_tick  = s1_fire;
      default:      ;
    endcase
  end

  // audio datapath
  logic [BYTE_W-1:0] audio_byte_next;
  logic              phase_next;

  pgac_audio #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_audio (
    .clk        (clk),
    .rst        (rst),
    .step       (step_audio),
    .sample     (s1_frame[SAMPLE_BITS-1:0]),
    .threshold  (max_jump),
    .byte_out   (audio_byte_next),
    .phase_next (phase_next)
  );

  // command, echo and tick control
  ctrl_status_t ctrl_status;

  pgac_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step_cmd     (step_cmd),
    .step_echo    (step_echo),
    .step_tick    (step_tick),
    .command_byte (s1_cmd),
    .capture_time (s1_time),
    .ticks_per_cm (ticks_per_cm),
    .status       (ctrl_status)
  );

  // audio byte goes out on the odd phase when recording or in manual mode
  logic audio_emit;
  assign audio_emit = step_audio && phase_next
                   && (ctrl_status.recording_on || !ctrl_status.distance_mode);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= audio_emit || step_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (step_tick) begin
        result_kind    <= KIND_TICK;
        audio_byte     <= '0;
        recording_flag <= ctrl_status.recording_next;
        trigger_pulse  <= ctrl_status.distance_mode;
      end else begin
        result_kind    <= KIND_AUDIO;
        audio_byte     <= audio_byte_next;
        recording_flag <= 1'b1;
        trigger_pulse  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_proximity_gated_audio_conditioner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_proximity_gated_audio_conditioner_core
// Self-checking bench for the proximity gated audio conditioner core.
// ----------------------------------------------------------------------------
// A clocked driver offers requests from a backlog that the stimulus process
// fills. A behavioral predictor updates its own copy of the block state at
// every accepted request and queues the result it expects. A clocked monitor
// pulls results with random back-pressure and checks them field by field.
// The stimulus starts with a short directed sequence, then runs a
// back-pressure burst, then random traffic under several register settings.
// ----------------------------------------------------------------------------
module tb_proximity_gated_audio_conditioner_core;
  import pgac_pkg::*;

  localparam int SB            = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX    = (1 << SB) - 1;
  localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 6;     // extra idle wait once the queues drain
  localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int RANDOM_ITEMS  = 270;   // per register setting
  localparam int BURST_ITEMS   = 60;
  localparam int IDLE_PCT      = 21;

  typedef struct packed {
    func_t              fn;
    logic [FRAME_W-1:0] frame;
    logic [CMD_W-1:0]   cmd;
    logic [TIME_W-1:0]  cap;
  } request_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] abyte;
    logic              rec;
    logic              trig;
  } outcome_t;

  // dut ports, all inputs known from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           func = '0;
  logic [FRAME_W-1:0]   audio_frame = '0;
  logic [CMD_W-1:0]     command_byte = '0;
  logic [TIME_W-1:0]    capture_time = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 result_kind;
  logic [BYTE_W-1:0]    audio_byte;
  logic                 recording_flag;
  logic                 trigger_pulse;

  // request backlog and expected results
  request_t req_backlog[$];
  request_t current_req;
  outcome_t awaited_results[$];

  // predictor copy of registers and state
  logic [THR_W-1:0]  jump_limit  = THR_RESET;
  logic [TPC_W-1:0]  tick_scale  = TPC_RESET;
  logic [SB-1:0]     prev_sample = SB'(1 << (SB - 1));
  logic              odd_frame   = 1'b0;
  logic              dist_mode   = 1'b0;
  logic              rec_on      = 1'b1;
  logic              in_entry    = 1'b0;
  logic [ACC_W-1:0]  entry_val   = '0;
  logic [NEAR_W-1:0] near_cm     = NEAR_RESET;
  logic              want_fall   = 1'b0;
  logic [TIME_W-1:0] rise_stamp  = '0;
  logic [TIME_W-1:0] echo_ticks  = '0;

  // stimulus side trackers, used only to shape the random traffic
  int gen_sample   = 1 << (SB - 1);
  int gen_near     = NEAR_RESET;
  bit gen_dist     = 1'b0;
  bit gen_awaiting = 1'b0;

  // run control and bookkeeping
  int send_idle_pct = IDLE_PCT;
  int recv_idle_pct = IDLE_PCT;
  int holds_asked   = 0;
  int holds_granted = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int queued_total  = 0;
  int mismatches    = 0;
  int bytes_seen    = 0;
  int status_seen   = 0;
  int accepted_by_func[4];

  proximity_gated_audio_conditioner_core DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .audio_frame    (audio_frame),
    .command_byte   (command_byte),
    .capture_time   (capture_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .audio_byte     (audio_byte),
    .recording_flag (recording_flag),
    .trigger_pulse  (trigger_pulse)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor: apply one accepted request, queue the result it causes
  // --------------------------------------------------------------------------
  function automatic void condition_item(input request_t r);
    logic [SB-1:0] s;
    logic [SB-1:0] gap;
    logic [SB:0]   mean;
    logic [16:0]   upper;
    outcome_t      o;
    accepted_by_func[r.fn]++;
    o = '0;
    case (r.fn)
      FUNC_AUDIO: begin
        // outlier rejection against the last kept sample, then 2:1 average
        s = r.frame[SB-1:0];
        gap = (s >= prev_sample) ? s - prev_sample : prev_sample - s;
        if (gap > jump_limit) s = prev_sample;
        mean = ({1'b0, s} + {1'b0, prev_sample}) >> 1;
        prev_sample = s;
        odd_frame = ~odd_frame;
        // byte out on every second frame, manual mode always records
        if (odd_frame && (rec_on || !dist_mode)) begin
          o.kind  = KIND_AUDIO;
          o.abyte = mean[SB-1 -: BYTE_W];
          o.rec   = 1'b1;
          awaited_results.push_back(o);
        end
      end
      FUNC_COMMAND: begin
        if (r.cmd == CH_M) begin
          dist_mode = 1'b0;
          rec_on    = 1'b1;
          in_entry  = 1'b0;
          entry_val = '0;
        end else if (r.cmd == CH_D) begin
          dist_mode = 1'b1;
          rec_on    = 1'b0;
          in_entry  = 1'b1;
          entry_val = '0;
        end else if (in_entry) begin
          if (r.cmd >= CH_0 && r.cmd <= CH_9) begin
            // decimal entry wraps at 16 bits
            entry_val = entry_val * 16'd10 + {8'd0, r.cmd - CH_0};
          end else if (r.cmd == CH_CR || r.cmd == CH_LF) begin
            if (entry_val != 0 && entry_val < NEAR_LIMIT_MAX) near_cm = entry_val[NEAR_W-1:0];
            in_entry  = 1'b0;
            entry_val = '0;
          end
        end
      end
      FUNC_ECHO: begin
        // rise and fall captures alternate, width is modulo 2^16
        if (dist_mode) begin
          if (!want_fall) begin
            rise_stamp = r.cap;
            want_fall  = 1'b1;
          end else begin
            echo_ticks = r.cap - rise_stamp;
            want_fall  = 1'b0;
          end
        end
      end
      FUNC_TICK: begin
        if (dist_mode) begin
          // strict window; an empty one when ticks per cm is zero
          upper  = tick_scale * near_cm;
          rec_on = (echo_ticks > tick_scale) && (echo_ticks < upper);
        end
        o.kind = KIND_TICK;
        o.rec  = rec_on;
        o.trig = dist_mode;
        awaited_results.push_back(o);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_req(input func_t fn, input logic [FRAME_W-1:0] frame,
                                   input logic [CMD_W-1:0] cmd,
                                   input logic [TIME_W-1:0] cap);
    request_t r;
    int       s;
    r.fn    = fn;
    r.frame = frame;
    r.cmd   = cmd;
    r.cap   = cap;
    req_backlog.push_back(r);
    queued_total++;
    // track mode, echo pairing and kept sample so random traffic stays coherent
    if (fn == FUNC_COMMAND) begin
      if (cmd == CH_M) gen_dist = 1'b0;
      else if (cmd == CH_D) gen_dist = 1'b1;
    end else if (fn == FUNC_ECHO && gen_dist) begin
      gen_awaiting = !gen_awaiting;
    end else if (fn == FUNC_AUDIO) begin
      s = frame[SB-1:0];
      if (s <= gen_sample + jump_limit && s + jump_limit >= gen_sample) gen_sample = s;
    end
  endfunction

  function automatic void push_audio(input logic [FRAME_W-1:0] f);
    push_req(FUNC_AUDIO, f, CMD_W'($urandom), TIME_W'($urandom));
  endfunction

  function automatic void push_cmd(input logic [CMD_W-1:0] c);
    push_req(FUNC_COMMAND, FRAME_W'($urandom), c, TIME_W'($urandom));
  endfunction

  function automatic void push_echo(input logic [TIME_W-1:0] t);
    push_req(FUNC_ECHO, FRAME_W'($urandom), CMD_W'($urandom), t);
  endfunction

  function automatic void push_tick();
    push_req(FUNC_TICK, FRAME_W'($urandom), CMD_W'($urandom), TIME_W'($urandom));
  endfunction

  // 'D', decimal digits, optional junk byte and optional line ending
  function automatic void queue_entry(input int num, input bit garbage, input bit terminate,
                                      input logic [CMD_W-1:0] ender);
    string            digits;
    logic [CMD_W-1:0] junk;
    int               wrapped;
    digits  = $sformatf("%0d", num);
    wrapped = num % 65536;
    push_cmd(CH_D);
    for (int i = 0; i < digits.len(); i++) begin
      push_cmd(digits[i]);
      if (garbage && i == 0) begin
        do junk = CMD_W'($urandom); while (junk == CH_M || junk == CH_D);
        push_cmd(junk);
      end
    end
    if (terminate) push_cmd(ender);
    if (terminate && !garbage && wrapped >= 1 && wrapped < 400) gen_near = wrapped;
  endfunction

  // random traffic: mostly coherent sequences, some noise
  function automatic void queue_traffic(input int n);
    int                 stop_at;
    int                 pick;
    int                 s;
    int                 w;
    int                 near_span;
    logic [FRAME_W-1:0] frame;
    logic [TIME_W-1:0]  rise;
    stop_at = queued_total + n;
    while (queued_total < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // audio burst, mostly near the kept sample with a few wild jumps
        repeat ($urandom_range(2, 8)) begin
          if ($urandom_range(0, 4) == 0) begin
            s = $urandom_range(0, SAMPLE_MAX);
          end else begin
            s = $urandom_range(0, jump_limit + 4);
            s = $urandom_range(0, 1) ? gen_sample + s : gen_sample - s;
            if (s < 0) s = 0;
            if (s > SAMPLE_MAX) s = SAMPLE_MAX;
          end
          frame = FRAME_W'($urandom);
          frame[SB-1:0] = SB'(s);
          push_audio(frame);
        end
      end else if (pick < 60) begin
        // echo pair then ticks, width aimed at the window edges
        if (!gen_dist && $urandom_range(0, 3) != 0) push_cmd(CH_D);
        if (gen_awaiting) push_echo(TIME_W'($urandom));
        near_span = tick_scale * gen_near;
        case ($urandom_range(0, 3))
          0:       w = $urandom_range(0, tick_scale + 1);
          1:       w = $urandom_range(0, near_span + 1);
          2:       w = near_span + $urandom_range(0, 2) - 1;
          default: w = $urandom;
        endcase
        rise = TIME_W'($urandom);
        push_echo(rise);
        push_echo(rise + w[TIME_W-1:0]);
        repeat ($urandom_range(1, 2)) push_tick();
      end else if (pick < 72) begin
        case ($urandom_range(0, 3))
          0, 1:    s = $urandom_range(1, 450);
          2:       s = $urandom_range(0, 99999);
          default: s = 65536 + $urandom_range(0, 420);
        endcase
        queue_entry(s, $urandom_range(0, 9) == 0, $urandom_range(0, 9) != 0,
                    $urandom_range(0, 1) ? CH_CR : CH_LF);
      end else if (pick < 77) begin
        push_cmd(CH_M);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 3)) push_tick();
      end else begin
        push_req(func_t'($urandom_range(0, 3)), FRAME_W'($urandom), CMD_W'($urandom),
                 TIME_W'($urandom));
      end
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THRESHOLD) jump_limit = data[THR_W-1:0];
    else tick_scale = data[TPC_W-1:0];
  endtask

  // wait until every request is taken and every result has come back
  task automatic wait_idle();
    do @(negedge clk); while (req_backlog.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // driver: one request at a time, valid held until accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    logic offering;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        condition_item(current_req);
        offering = 1'b0;
      end
      // a new request goes out right away unless this cycle idles
      if (!offering) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          current_req = req_backlog.pop_front();
          in_valid     <= 1'b1;
          func         <= current_req.fn;
          audio_frame  <= current_req.frame;
          command_byte <= current_req.cmd;
          capture_time <= current_req.cap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: check each result against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    outcome_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected: kind %0d byte %0d",
                                  result_kind, audio_byte));
        end else begin
          want = awaited_results.pop_front();
          if (result_kind !== want.kind)
            flag_mismatch($sformatf("result_kind %b, want %b", result_kind, want.kind));
          if (audio_byte !== want.abyte)
            flag_mismatch($sformatf("audio_byte %0d, want %0d", audio_byte, want.abyte));
          if (recording_flag !== want.rec)
            flag_mismatch($sformatf("recording_flag %b, want %b", recording_flag, want.rec));
          if (trigger_pulse !== want.trig)
            flag_mismatch($sformatf("trigger_pulse %b, want %b", trigger_pulse, want.trig));
          if (want.kind == KIND_AUDIO) bytes_seen++;
          else status_seen++;
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (holds_granted != holds_asked) begin
        holds_granted++;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any handshake ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    int               setting;
    int               thr_val;
    int               tpc_val;
    logic [CFG_W-1:0] word;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset register values
    push_audio(16'hFFFF);            // top sample, rejected as outlier
    push_audio(16'h0000);            // bottom sample, rejected as outlier
    push_audio(16'hFE12);            // in range jump, upper frame bits set
    push_tick();                     // manual mode status
    push_cmd(8'hFF);                 // ignored outside an entry
    queue_entry(65636, 1'b0, 1'b1, CH_CR);   // entry wraps at 16 bits to 100
    push_echo(16'hFFF0);             // echo width wraps through zero
    push_echo(16'h0010);
    push_tick();                     // width below one centimetre
    push_echo(16'h0000);
    push_echo(16'h03E8);
    push_tick();                     // width inside the window
    push_audio(16'h03FF);            // recording in distance mode
    queue_entry(400, 1'b0, 1'b1, CH_LF);     // out of range limit, ignored
    push_cmd(CH_M);
    push_tick();
    wait_idle();

    // back-pressure burst: receiver holds while the sender keeps offering
    send_idle_pct = 0;
    holds_asked++;
    repeat (BURST_ITEMS / 2) begin
      push_tick();
      push_audio(FRAME_W'($urandom));
    end
    wait_idle();

    // random traffic under several register settings
    for (setting = 0; setting < 5; setting++) begin
      case (setting)
        0: begin
          thr_val = 0;
          tpc_val = 1;
        end
        1: begin
          thr_val = (1 << THR_W) - 1;
          tpc_val = (1 << TPC_W) - 1;
        end
        2: begin
          // zero ticks per cm leaves an empty distance window
          thr_val = $urandom_range(0, 300);
          tpc_val = 0;
        end
        3: begin
          thr_val = $urandom_range(0, (1 << THR_W) - 1);
          tpc_val = $urandom_range(1, (1 << TPC_W) - 1);
        end
        default: begin
          thr_val = $urandom_range(40, 120);
          tpc_val = TPC_RESET;
        end
      endcase
      // unused upper data bits of the ticks register are random
      word = CFG_W'($urandom);
      word[TPC_W-1:0] = TPC_W'(tpc_val);
      write_reg(CFG_THRESHOLD, CFG_W'(thr_val));
      write_reg(CFG_TICKS, word);
      // one full setting with no idling on either side
      send_idle_pct = (setting == 2) ? 0 : IDLE_PCT;
      recv_idle_pct = (setting == 2) ? 0 : IDLE_PCT;
      @(negedge clk);
      queue_traffic(RANDOM_ITEMS);
      wait_idle();
    end

    $display("covered %0d requests: %0d audio frames, %0d command bytes,",
             queued_total, accepted_by_func[FUNC_AUDIO], accepted_by_func[FUNC_COMMAND]);
    $display("  %0d echo captures, %0d ticks; checked %0d audio bytes and %0d status results",
             accepted_by_func[FUNC_ECHO], accepted_by_func[FUNC_TICK], bytes_seen,
             status_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pgac_pkg.sv
rtl/core/pgac_audio.sv
rtl/core/pgac_ctrl.sv
rtl/core/proximity_gated_audio_conditioner_core.sv
bench/tb_proximity_gated_audio_conditioner_core.sv
